/* hw/rtl/fpfa_pkg.sv */
// ---------------------------------------------------------------------------
// fpfa_pkg
// shared types, widths and codes of the fixed partition fit allocator
// ---------------------------------------------------------------------------
package fpfa_pkg;

   localparam int NUM_PARTITIONS = 8;
   localparam int SIZE_BITS      = 16;

   // widths of the transaction fields
   localparam int PIDX_BITS   = 3;
   localparam int POLICY_BITS = 2;

   // internal widths derived from the table depth
   localparam int IDX_BITS = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;
   localparam int CNT_BITS = $clog2(NUM_PARTITIONS + 1);

   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_ALLOC = 1'b1;

   localparam logic [POLICY_BITS-1:0] POL_FIRST = 2'd0;
   localparam logic [POLICY_BITS-1:0] POL_WORST = 2'd1;
   localparam logic [POLICY_BITS-1:0] POL_BEST  = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

endpackage

/* hw/rtl/fpfa_if.sv */
// ---------------------------------------------------------------------------
// fpfa channel interfaces
// request, response and register write channels with valid/ready
// ---------------------------------------------------------------------------
interface fpfa_req_if
   import fpfa_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic                 action;
   logic [PIDX_BITS-1:0] partition_index;
   logic [SIZE_BITS-1:0] partition_size;
   logic [SIZE_BITS-1:0] request_size;

   modport source (output valid, action, partition_index, partition_size, request_size,
                   input ready);
   modport sink   (input valid, action, partition_index, partition_size, request_size,
                   output ready);
endinterface

interface fpfa_rsp_if
   import fpfa_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic                 granted;
   logic [PIDX_BITS-1:0] chosen_index;
   logic [SIZE_BITS-1:0] chosen_size;
   logic [SIZE_BITS-1:0] leftover;

   modport source (output valid, granted, chosen_index, chosen_size, leftover,
                   input ready);
   modport sink   (input valid, granted, chosen_index, chosen_size, leftover,
                   output ready);
endinterface

interface fpfa_csr_if
   import fpfa_pkg::*;
   ();
   logic                   valid;
   logic                   ready;
   logic [POLICY_BITS-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

/* hw/rtl/fixed_partition_fit_allocator_core.sv */
// ---------------------------------------------------------------------------
// fixed_partition_fit_allocator_core
// partition table with first, worst and best fit allocation
// ---------------------------------------------------------------------------
// load transaction: written in the accept cycle, no response
// allocate transaction: scans every entry in turn, then commits its response to the
//    response register, waiting in the done state while that register is full; the
//    serial scan runs through the single read port of the size memory, and no new
//    request is accepted until the commit returns the core to the idle state
// reset (synchronous, active high) clears all free marks and the policy register;
//    the size memory is not cleared, entries are only used once a load marks them free
module fixed_partition_fit_allocator_core
   import fpfa_pkg::*;
(
   input logic           clock,
   input logic           reset,
   fpfa_req_if.sink      req_chan,
   fpfa_rsp_if.source    rsp_chan,
   fpfa_csr_if.sink      csr_chan
);

   // size table, one synchronous read port
   logic [SIZE_BITS-1:0] size_mem [NUM_PARTITIONS];

   // free marks in flops, cleared by reset
   logic [NUM_PARTITIONS-1:0] part_free_ff;
   logic [NUM_PARTITIONS-1:0] part_free_in;

   logic [POLICY_BITS-1:0] fit_policy_ff;

   state_type state_ff, state_in;

   // scan pipeline: address issue, then compare in the cycle after
   logic [CNT_BITS-1:0]  rd_addr_ff, rd_addr_in;
   logic [SIZE_BITS-1:0] rd_data_ff;
   logic                 data_vld_ff;
   logic [IDX_BITS-1:0]  data_idx_ff;
   logic                 issue;

   // allocate request latched at accept
   logic [SIZE_BITS-1:0]   req_size_ff;
   logic [POLICY_BITS-1:0] policy_ff;

   // running choice of the scan
   logic                 found_ff, found_in;
   logic [IDX_BITS-1:0]  pick_ff, pick_in;
   logic [SIZE_BITS-1:0] best_ff, best_in;

   // response register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_granted_ff;
   logic [PIDX_BITS-1:0] rsp_index_ff;
   logic [SIZE_BITS-1:0] rsp_size_ff;
   logic [SIZE_BITS-1:0] rsp_left_ff;
   logic                 rsp_load;

   logic req_fire, load_fire, alloc_fire, load_in_range, fits, take, out_free;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;

   assign req_fire      = req_chan.valid && req_chan.ready;
   assign load_in_range = (32'(req_chan.partition_index) < 32'(NUM_PARTITIONS));
   assign load_fire     = req_fire && (req_chan.action == ACT_LOAD) && load_in_range;
   assign alloc_fire    = req_fire && (req_chan.action == ACT_ALLOC);

   assign issue    = (state_ff == ST_SCAN) && (rd_addr_ff < CNT_BITS'(NUM_PARTITIONS));
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // entry under compare: free and large enough
   assign fits = data_vld_ff && part_free_ff[data_idx_ff] && (rd_data_ff >= req_size_ff);

   // replace the current choice; first fit (and the unused code) keeps the first hit
   always_comb begin
      take = 1'b0;
      if (fits) begin
         if (!found_ff) begin
            take = 1'b1;
         end else begin
            case (policy_ff)
               POL_WORST: take = (rd_data_ff > best_ff);
               // both sizes cover the request, so the smaller size is the smaller leftover
               POL_BEST:  take = (rd_data_ff < best_ff);
               default:   take = 1'b0;
            endcase
         end
      end
   end

   // next state and control
   always_comb begin
      state_in     = state_ff;
      rd_addr_in   = rd_addr_ff;
      found_in     = found_ff;
      pick_in      = pick_ff;
      best_in      = best_ff;
      part_free_in = part_free_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_load     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (load_fire) begin
               part_free_in[IDX_BITS'(req_chan.partition_index)] = 1'b1;
            end
            if (alloc_fire) begin
               rd_addr_in = '0;
               found_in   = 1'b0;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (issue) begin
               rd_addr_in = rd_addr_ff + CNT_BITS'(1);
            end
            if (take) begin
               found_in = 1'b1;
               pick_in  = data_idx_ff;
               best_in  = rd_data_ff;
            end
            // the last entry is compared in the cycle after its read
            if (!issue) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // commit waits for room in the response register
            if (out_free) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               if (found_ff) begin
                  part_free_in[pick_ff] = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         part_free_ff  <= '0;
         fit_policy_ff <= POL_FIRST;
         rd_addr_ff    <= '0;
         data_vld_ff   <= 1'b0;
         found_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         part_free_ff <= part_free_in;
         rd_addr_ff   <= rd_addr_in;
         data_vld_ff  <= issue;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_chan.valid && csr_chan.ready) begin
            fit_policy_ff <= csr_chan.data;
         end
      end
   end

   // size memory: write on load, registered read during the scan
   always_ff @(posedge clock) begin
      if (load_fire) begin
         size_mem[IDX_BITS'(req_chan.partition_index)] <= req_chan.partition_size;
      end
      if (issue) begin
         rd_data_ff <= size_mem[rd_addr_ff[IDX_BITS-1:0]];
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      data_idx_ff <= rd_addr_ff[IDX_BITS-1:0];
      pick_ff     <= pick_in;
      best_ff     <= best_in;
      if (alloc_fire) begin
         req_size_ff <= req_chan.request_size;
         policy_ff   <= fit_policy_ff;
      end
      if (rsp_load) begin
         rsp_granted_ff <= found_ff;
         // a refused request reports all zero fields
         rsp_index_ff   <= found_ff ? PIDX_BITS'(pick_ff) : '0;
         rsp_size_ff    <= found_ff ? best_ff : '0;
         rsp_left_ff    <= found_ff ? (best_ff - req_size_ff) : '0;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.granted      = rsp_granted_ff;
   assign rsp_chan.chosen_index = rsp_index_ff;
   assign rsp_chan.chosen_size  = rsp_size_ff;
   assign rsp_chan.leftover     = rsp_left_ff;

endmodule

/* hw/rtl/fpfa_checker.sv */
// ---------------------------------------------------------------------------
// fpfa_checker
// port level checks of the allocator core, bound into the core module
// ---------------------------------------------------------------------------
module fpfa_checker
   import fpfa_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 req_action,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic                 rsp_granted,
   input logic [PIDX_BITS-1:0] rsp_chosen_index,
   input logic [SIZE_BITS-1:0] rsp_chosen_size,
   input logic [SIZE_BITS-1:0] rsp_leftover
);

   // a stalled response stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // refused request reports zero fields
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_granted |->
         rsp_chosen_index == '0 && rsp_chosen_size == '0 && rsp_leftover == '0)
      else $error("refused response with nonzero fields");

   // leftover never exceeds the granted partition size
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_granted |-> rsp_leftover <= rsp_chosen_size)
      else $error("leftover larger than chosen size");

   // an allocate transaction blocks the request side once accepted, as its scan starts
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_action == ACT_ALLOC |=> !req_ready)
      else $error("request accepted during a scan");

endmodule

bind fixed_partition_fit_allocator_core fpfa_checker u_fpfa_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .req_action       (req_chan.action),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_granted      (rsp_chan.granted),
   .rsp_chosen_index (rsp_chan.chosen_index),
   .rsp_chosen_size  (rsp_chan.chosen_size),
   .rsp_leftover     (rsp_chan.leftover)
);
